[src/i2c_rtm_pkg.sv]
`default_nettype none

package i2c_rtm_pkg;

    // input word modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_WBYTE  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // sequencer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_SLAW   = 4'd2;
    localparam logic [3:0] PH_REG    = 4'd3;
    localparam logic [3:0] PH_HOST   = 4'd4;
    localparam logic [3:0] PH_WDATA  = 4'd5;
    localparam logic [3:0] PH_RSTART = 4'd6;
    localparam logic [3:0] PH_SLAR   = 4'd7;
    localparam logic [3:0] PH_RACK   = 4'd8;
    localparam logic [3:0] PH_RNACK  = 4'd9;

    // bus engine actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_SEND  = 3'd2;
    localparam logic [2:0] ACT_RACK  = 3'd3;
    localparam logic [2:0] ACT_RNACK = 3'd4;
    localparam logic [2:0] ACT_STOP  = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_START   = 2'd1;
    localparam logic [1:0] ERR_RESTART = 2'd2;
    localparam logic [1:0] ERR_NOACK   = 2'd3;

    // engine status codes, low three bits masked
    localparam logic [7:0] STATUS_MASK   = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic        read_not_write;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] length;
        logic [7:0]  status_code;
        logic [7:0]  byte_value;
    } t_item;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       data_request;
        logic       done_res;
        logic [1:0] error_code;
    } t_result;

endpackage

`default_nettype wire

[src/i2c_rtm_in_if.sv]
`default_nettype none

interface i2c_rtm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        read_not_write;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] length;
    logic [7:0]  status_code;
    logic [7:0]  byte_value;

    modport source (
        output valid, mode, read_not_write, dev_addr, reg_addr, length,
               status_code, byte_value,
        input  ready
    );
    modport sink (
        input  valid, mode, read_not_write, dev_addr, reg_addr, length,
               status_code, byte_value,
        output ready
    );
endinterface

`default_nettype wire

[src/i2c_rtm_out_if.sv]
`default_nettype none

interface i2c_rtm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       data_request;
    logic       done_res;
    logic [1:0] error_code;

    modport source (
        output valid, bus_action, tx_byte, rx_valid, rx_byte, data_request,
               done_res, error_code,
        input  ready
    );
    modport sink (
        input  valid, bus_action, tx_byte, rx_valid, rx_byte, data_request,
               done_res, error_code,
        output ready
    );
endinterface

`default_nettype wire

[src/i2c_rtm_core.sv]
`default_nettype none

module i2c_rtm_core
    import i2c_rtm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_item       i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output t_result          o_res,
    output logic             o_res_hit
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    typedef logic [CMP_W-1:0] t_cmp;

    logic [15:0]            r_limit;
    logic [3:0]             r_phase,  n_phase;
    logic                   r_reading, n_reading;
    logic [6:0]             r_dev,    n_dev;
    logic [7:0]             r_reg,    n_reg;
    logic [15:0]            r_left,   n_left;
    logic [COUNT_WIDTH-1:0] r_wait,   n_wait;

    logic [7:0]             status;
    logic [7:0]             expected;
    logic                   expected_ok;
    logic [COUNT_WIDTH-1:0] wait_inc;
    logic [1:0]             tmo_code;

    assign status = i_item.status_code & STATUS_MASK;

    // status the current phase is waiting for
    always_comb begin
        expected    = ST_START;
        expected_ok = 1'b1;
        unique case (r_phase)
            PH_START:  expected = ST_START;
            PH_RSTART: expected = ST_RSTART;
            PH_SLAW:   expected = ST_SLAW_ACK;
            PH_REG:    expected = ST_DATA_ACK;
            PH_WDATA:  expected = ST_DATA_ACK;
            PH_SLAR:   expected = ST_SLAR_ACK;
            PH_RACK:   expected = ST_RX_ACK;
            PH_RNACK:  expected = ST_RX_NACK;
            default:   expected_ok = 1'b0;
        endcase
    end

    // error reported on timeout
    always_comb begin
        unique case (r_phase)
            PH_START:  tmo_code = ERR_START;
            PH_RSTART: tmo_code = ERR_RESTART;
            PH_RNACK:  tmo_code = ERR_START;
            default:   tmo_code = ERR_NOACK;
        endcase
    end

    // saturating wait count
    assign wait_inc = (r_wait != '1) ? r_wait + COUNT_WIDTH'(1) : r_wait;

    // next state and result for one word
    always_comb begin
        n_phase   = r_phase;
        n_reading = r_reading;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_left    = r_left;
        n_wait    = r_wait;
        o_res     = '0;
        o_res_hit = 1'b0;

        if (i_accept) begin
            unique case (i_item.mode)
                MODE_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_reading = i_item.read_not_write;
                        n_dev     = i_item.dev_addr;
                        n_reg     = i_item.reg_addr;
                        n_left    = (i_item.read_not_write && i_item.length == 16'd0)
                                    ? 16'd1 : i_item.length;
                        n_wait    = '0;
                        n_phase   = PH_START;
                        o_res.bus_action = ACT_START;
                        o_res_hit = 1'b1;
                    end
                end
                MODE_WBYTE: begin
                    if (r_phase == PH_HOST) begin
                        n_left    = r_left - 16'd1;
                        n_wait    = '0;
                        n_phase   = PH_WDATA;
                        o_res.bus_action = ACT_SEND;
                        o_res.tx_byte    = i_item.byte_value;
                        o_res_hit = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (r_phase != PH_IDLE && r_phase != PH_HOST) begin
                        if (t_cmp'(wait_inc) >= t_cmp'(r_limit)) begin
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                            o_res.bus_action = ACT_STOP;
                            o_res.done_res   = 1'b1;
                            o_res.error_code = tmo_code;
                            o_res_hit = 1'b1;
                        end else begin
                            n_wait = wait_inc;
                        end
                    end
                end
                default: begin
                    // bus status event
                    if (expected_ok && status == expected) begin
                        n_wait = '0;
                        unique case (r_phase)
                            PH_START: begin
                                n_phase = PH_SLAW;
                                o_res.bus_action = ACT_SEND;
                                o_res.tx_byte    = {r_dev, 1'b0};
                                o_res_hit = 1'b1;
                            end
                            PH_SLAW: begin
                                n_phase = PH_REG;
                                o_res.bus_action = ACT_SEND;
                                o_res.tx_byte    = r_reg;
                                o_res_hit = 1'b1;
                            end
                            PH_RSTART: begin
                                n_phase = PH_SLAR;
                                o_res.bus_action = ACT_SEND;
                                o_res.tx_byte    = {r_dev, 1'b1};
                                o_res_hit = 1'b1;
                            end
                            PH_REG, PH_WDATA: begin
                                o_res_hit = 1'b1;
                                if (r_phase == PH_REG && r_reading) begin
                                    n_phase = PH_RSTART;
                                    o_res.bus_action = ACT_START;
                                end else if (r_left == 16'd0) begin
                                    n_phase = PH_IDLE;
                                    o_res.bus_action = ACT_STOP;
                                    o_res.done_res   = 1'b1;
                                end else begin
                                    n_phase = PH_HOST;
                                    o_res.data_request = 1'b1;
                                end
                            end
                            PH_SLAR, PH_RACK: begin
                                o_res_hit = 1'b1;
                                if (r_phase == PH_RACK) begin
                                    n_left = r_left - 16'd1;
                                    o_res.rx_valid = 1'b1;
                                    o_res.rx_byte  = i_item.byte_value;
                                end
                                // ACK while more than one byte remains
                                if (n_left > 16'd1) begin
                                    n_phase = PH_RACK;
                                    o_res.bus_action = ACT_RACK;
                                end else begin
                                    n_phase = PH_RNACK;
                                    o_res.bus_action = ACT_RNACK;
                                end
                            end
                            PH_RNACK: begin
                                n_left  = 16'd0;
                                n_phase = PH_IDLE;
                                o_res.bus_action = ACT_STOP;
                                o_res.rx_valid   = 1'b1;
                                o_res.rx_byte    = i_item.byte_value;
                                o_res.done_res   = 1'b1;
                                o_res_hit = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= TIMEOUT_RESET;
            r_phase   <= PH_IDLE;
            r_reading <= 1'b0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_left    <= '0;
            r_wait    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_phase   <= n_phase;
            r_reading <= n_reading;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_left    <= n_left;
            r_wait    <= n_wait;
        end
    end

endmodule

`default_nettype wire

[src/i2c_rtm_out_reg.sv]
`default_nettype none

module i2c_rtm_out_reg
    import i2c_rtm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    i2c_rtm_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    // slot can take a new word when empty or draining this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.bus_action   = r_res.bus_action;
    assign o_out.tx_byte      = r_res.tx_byte;
    assign o_out.rx_valid     = r_res.rx_valid;
    assign o_out.rx_byte      = r_res.rx_byte;
    assign o_out.data_request = r_res.data_request;
    assign o_out.done_res     = r_res.done_res;
    assign o_out.error_code   = r_res.error_code;

endmodule

`default_nettype wire

[src/i2c_register_transaction_master.sv]
// A result word is registered in the output register and appears there in the cycle after its input word is taken.
// Throughput: one input word per cycle; input ready follows output ready while a result waits.
// Words that cause no result (ignored events, counting ticks) are still accepted and load no result word.
// Reset: synchronous, active low; phase idle, counters cleared, timeout limit 65535.
`default_nettype none

module i2c_register_transaction_master
    import i2c_rtm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    i2c_rtm_in_if.sink       i_in,
    i2c_rtm_out_if.source    o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);

    t_item   item;
    t_result res;
    logic    res_hit;
    logic    free;
    logic    accept;

    assign item = '{
        mode:           i_in.mode,
        read_not_write: i_in.read_not_write,
        dev_addr:       i_in.dev_addr,
        reg_addr:       i_in.reg_addr,
        length:         i_in.length,
        status_code:    i_in.status_code,
        byte_value:     i_in.byte_value
    };

    assign i_in.ready = free;
    assign accept     = i_in.valid && free;

    i2c_rtm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (res),
        .o_res_hit  (res_hit)
    );

    i2c_rtm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_hit),
        .i_res   (res),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
